// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, s-box tables and gf helpers for the aes-128 cipher
// used by aes_kx, aes_round and aes128_block_cipher; no dependencies
package aes_pkg;

	localparam int ROUNDS_DEF = 10;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} out_item_t;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_KEY_HI = 2'd0,
		REG_KEY_LO = 2'd1
	} reg_idx_t;

	function automatic logic [7:0] fwd_box(input logic [7:0] a);
		logic [7:0] t [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] inv_box(input logic [7:0] a);
		logic [7:0] t [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {fwd_box(w[31:24]), fwd_box(w[23:16]), fwd_box(w[15:8]), fwd_box(w[7:0])};
	endfunction

endpackage

// ===== rtl/aes_kx.sv =====
// aes_kx: one key-schedule cell, turns round key n-1 into round key n
// depends on aes_pkg
module aes_kx (
	input  logic         clk,
	input  logic [127:0] key_in,
	input  logic [7:0]   rcon_in,
	output logic [127:0] key_q,
	output logic [7:0]   rcon_q
);
	import aes_pkg::*;

	logic [31:0] t, w0, w1, w2, w3;

	always_comb begin
		t  = sub_word({key_in[23:0], key_in[31:24]}) ^ {rcon_in, 24'h0};
		w0 = key_in[127:96] ^ t;
		w1 = key_in[95:64] ^ w0;
		w2 = key_in[63:32] ^ w1;
		w3 = key_in[31:0] ^ w2;
	end

	// registered, so a new key settles through the chain of schedule cells after a key write
	always_ff @(posedge clk) begin
		key_q  <= {w0, w1, w2, w3};
		rcon_q <= xtime(rcon_in);
	end
endmodule

// ===== rtl/aes_round.sv =====
// aes_round: one cipher cell, an encrypt or decrypt round on its input item, without mix columns when last
// depends on aes_pkg
module aes_round (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic         dec_in,
	input  logic         last,
	input  logic [127:0] state_in,
	input  logic [127:0] rk_in,
	output logic         vld_q,
	output logic         dec_q,
	output logic [127:0] state_q
);
	import aes_pkg::*;

	logic [7:0] b [16];
	logic [7:0] sb [16];
	logic [7:0] m [16];
	logic [7:0] k [16];
	logic [7:0] x2, x4, x8, a0, a1, a2, a3;
	logic [127:0] nxt;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			b[i] = state_in[127-8*i -: 8];
			k[i] = rk_in[127-8*i -: 8];
		end
		// shift rows then s-box; both orders are equivalent per byte
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (dec_in)
					sb[c*4+r] = inv_box(b[((c + 3*r) & 3)*4 + r]);
				else
					sb[c*4+r] = fwd_box(b[((c + r) & 3)*4 + r]);
			end
		end
		// decrypt adds the key before inverse mix columns
		for (int i = 0; i < 16; i++)
			if (dec_in) sb[i] = sb[i] ^ k[i];
		for (int c = 0; c < 4; c++) begin
			a0 = sb[c*4]; a1 = sb[c*4+1]; a2 = sb[c*4+2]; a3 = sb[c*4+3];
			for (int r = 0; r < 4; r++) begin
				m[c*4+r] = 8'h0;
				for (int j = 0; j < 4; j++) begin
					x2 = xtime(sb[c*4+j]);
					x4 = xtime(x2);
					x8 = xtime(x4);
					if (dec_in) begin
						case ((j - r) & 3)
							0: m[c*4+r] ^= x8 ^ x4 ^ x2;
							1: m[c*4+r] ^= x8 ^ x2 ^ sb[c*4+j];
							2: m[c*4+r] ^= x8 ^ x4 ^ sb[c*4+j];
							default: m[c*4+r] ^= x8 ^ sb[c*4+j];
						endcase
					end else begin
						case ((j - r) & 3)
							0: m[c*4+r] ^= x2;
							1: m[c*4+r] ^= x2 ^ sb[c*4+j];
							default: m[c*4+r] ^= sb[c*4+j];
						endcase
					end
				end
			end
			if (last) begin
				m[c*4] = a0; m[c*4+1] = a1; m[c*4+2] = a2; m[c*4+3] = a3;
			end
		end
		for (int i = 0; i < 16; i++)
			nxt[127-8*i -: 8] = dec_in ? m[i] : (m[i] ^ k[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_q   <= dec_in;
			state_q <= nxt;
		end
	end
endmodule

// ===== rtl/aes128_block_cipher.sv =====
// aes128_block_cipher: aes-128 ecb encrypt/decrypt, a chain of round cells
// depends on aes_pkg, aes_kx, aes_round
//
//  channel | signals                          | accepted when
//  in      | in_valid, in_stall, in_data      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data   | out_valid && !out_stall
//  cfg     | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// one item per cycle unless out_stall or a key settle holds the input; each item passes
// through ROUNDS+1 register stages (the entry cell and one cell per round)
// a key write rebuilds the round keys through ROUNDS registered schedule cells;
// the input stalls after reset and each key write until settle_q counts down to zero
// the whole chain advances only when its last cell is empty or is being taken
// reset clears valid flags and the key registers
module aes128_block_cipher #(
	parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  aes_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output aes_pkg::out_item_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import aes_pkg::*;

	localparam int SETTLE_W = $clog2(ROUNDS + 1);

	logic [127:0] key_q;
	logic [127:0] rk [ROUNDS+1];
	logic [7:0]   rc [ROUNDS+1];
	logic         vld [ROUNDS+1];
	logic         dec [ROUNDS+1];
	logic [127:0] st  [ROUNDS+1];
	logic         en;
	logic         rsel;
	logic         cfg_wr;
	logic [SETTLE_W-1:0] settle_q;

	assign pready = 1'b1;
	assign rsel   = paddr[3];
	assign cfg_wr = psel && penable && pwrite && paddr[2:0] == 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr) begin
			if ({1'b0, paddr[3]} == REG_KEY_HI) key_q[127:64] <= pwdata;
			else                                key_q[63:0]   <= pwdata;
		end
	end

	// counts down while the schedule cells take up a new key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(ROUNDS);
		end else if (cfg_wr) begin
			settle_q <= SETTLE_W'(ROUNDS);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0)
			prdata = rsel ? key_q[63:0] : key_q[127:64];
	end

	assign rk[0] = key_q;
	assign rc[0] = 8'h01;

	for (genvar g = 0; g < ROUNDS; g++) begin : g_kx
		aes_kx u_kx (
			.clk(clk), .key_in(rk[g]), .rcon_in(rc[g]),
			.key_q(rk[g+1]), .rcon_q(rc[g+1])
		);
	end

	assign en       = !vld[ROUNDS] || !out_stall;
	assign in_stall = !en || settle_q != '0;

	// entry cell: initial add-round-key, key 0 or key ROUNDS by direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid && settle_q == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec[0] <= in_data.cmd;
			st[0]  <= {in_data.block_hi, in_data.block_lo} ^
				(in_data.cmd == OP_DEC ? rk[ROUNDS] : rk[0]);
		end
	end

	for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
		aes_round u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld[g]), .dec_in(dec[g]),
			.last(dec[g] ? (g == ROUNDS-1) : (g == ROUNDS-1)),
			.state_in(st[g]),
			.rk_in(dec[g] ? rk[ROUNDS-1-g] : rk[g+1]),
			.vld_q(vld[g+1]), .dec_q(dec[g+1]), .state_q(st[g+1])
		);
	end

	assign out_valid          = vld[ROUNDS];
	assign out_data.result_hi = st[ROUNDS][127:64];
	assign out_data.result_lo = st[ROUNDS][63:0];
endmodule
